/* rtl/core/spp_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Servo position PID package
// Shared constants, register index codes and the structs passed between the
// servo position PID stages.
// ----------------------------------------------------------------------------
package spp_pkg;

   localparam int POSITION_MAX_DEFAULT       = 4096;
   localparam int OUTPUT_LIMIT_DEFAULT       = 255;
   localparam int GAIN_FRACTION_BITS_DEFAULT = 8;

   localparam int INTEG_W     = 16;
   localparam int GAIN_W      = 16;
   localparam int LIMIT_W     = 16;
   localparam int DEADBAND_W  = 8;
   localparam int WINDUP_W    = 15;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   localparam logic [WINDUP_W-1:0] WINDUP_RESET = '1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_DEADBAND      = 3'd0,
      CSR_PROP_GAIN     = 3'd1,
      CSR_INTEG_GAIN    = 3'd2,
      CSR_DERIV_GAIN    = 3'd3,
      CSR_LOWER_LIMIT   = 3'd4,
      CSR_UPPER_LIMIT   = 3'd5,
      CSR_REVERSE_SENSE = 3'd6,
      CSR_WINDUP_LIMIT  = 3'd7
   } csr_reg_type;

   typedef struct packed {
      logic [DEADBAND_W-1:0] deadband;
      logic [GAIN_W-1:0]     prop_gain;
      logic [GAIN_W-1:0]     integ_gain;
      logic [GAIN_W-1:0]     deriv_gain;
      logic [LIMIT_W-1:0]    lower_limit;
      logic [LIMIT_W-1:0]    upper_limit;
      logic                  reverse_sense;
      logic [WINDUP_W-1:0]   windup_limit;
   } cfg_type;

   typedef struct packed {
      logic                      outside;
      logic signed [INTEG_W-1:0] err;
      logic signed [INTEG_W-1:0] integ;
      logic signed [INTEG_W-1:0] deriv;
   } terms_type;

endpackage
`default_nettype wire

/* rtl/core/spp_error_stage.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Servo position PID error stage
// Mirrors and clamps the target, forms the position error and derivative,
// updates the wind-up limited integral and registers the three terms.
// ----------------------------------------------------------------------------
module spp_error_stage #(
   parameter int POSITION_MAX = spp_pkg::POSITION_MAX_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  spp_pkg::cfg_type                  cfg,
   input  logic                              load,
   input  logic [$clog2(POSITION_MAX+1)-1:0] measured_position,
   input  logic [$clog2(POSITION_MAX+1)-1:0] target_position,
   input  logic                              tick,
   output spp_pkg::terms_type                terms
);
   import spp_pkg::*;

   localparam int POS_W = $clog2(POSITION_MAX + 1);
   localparam int SW    = POS_W + 1;
   localparam int SUM_W = INTEG_W + 1;
   localparam logic signed [SW-1:0] PMAX = SW'(POSITION_MAX);

   logic                      started_ff, started_in;
   logic [POS_W-1:0]          last_ff, last_in;
   logic signed [INTEG_W-1:0] integ_ff, integ_in;
   terms_type                 terms_ff, terms_in;

   logic signed [SW-1:0]      pos_s, tgt_raw, lo_raw, hi_raw;
   logic signed [SW-1:0]      tgt_m, lo_m, hi_m;
   logic signed [SW-1:0]      clamp_lo, clamp_hi, clamp_zero, tgt_c;
   logic signed [SW-1:0]      last_s, err, deriv, db_s;
   logic signed [INTEG_W-1:0] integ_base, integ_tick;
   logic signed [SUM_W-1:0]   sum, wl_s, sum_c;
   logic                      outside;

   always_comb begin
      pos_s   = $signed({1'b0, measured_position});
      tgt_raw = $signed({1'b0, target_position});
      lo_raw  = $signed({1'b0, cfg.lower_limit[POS_W-1:0]});
      hi_raw  = $signed({1'b0, cfg.upper_limit[POS_W-1:0]});

      if (cfg.reverse_sense) begin
         tgt_m = PMAX - tgt_raw;
         lo_m  = PMAX - lo_raw;
         hi_m  = PMAX - hi_raw;
      end else begin
         tgt_m = tgt_raw;
         lo_m  = lo_raw;
         hi_m  = hi_raw;
      end

      clamp_lo   = (tgt_m < lo_m) ? lo_m : tgt_m;
      clamp_hi   = (clamp_lo > hi_m) ? hi_m : clamp_lo;
      clamp_zero = (clamp_hi < $signed(SW'(0))) ? $signed(SW'(0)) : clamp_hi;
      tgt_c      = (clamp_zero > PMAX) ? PMAX : clamp_zero;

      last_s     = started_ff ? $signed({1'b0, last_ff}) : pos_s;
      integ_base = started_ff ? integ_ff : $signed(INTEG_W'(0));

      err   = tgt_c - pos_s;
      deriv = last_s - pos_s;

      sum  = SUM_W'(integ_base) + SUM_W'(err);
      wl_s = $signed({2'b00, cfg.windup_limit});
      if (sum < -wl_s) begin
         sum_c = -wl_s;
      end else if (sum > wl_s) begin
         sum_c = wl_s;
      end else begin
         sum_c = sum;
      end
      integ_tick = tick ? sum_c[INTEG_W-1:0] : integ_base;

      db_s    = $signed({{(SW - DEADBAND_W){1'b0}}, cfg.deadband});
      outside = (err > db_s) || (err < -db_s);

      started_in = 1'b1;
      last_in    = measured_position;
      integ_in   = outside ? integ_tick : $signed(INTEG_W'(0));

      terms_in.outside = outside;
      terms_in.err     = INTEG_W'(err);
      terms_in.integ   = integ_tick;
      terms_in.deriv   = INTEG_W'(deriv);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff <= 1'b0;
         last_ff    <= '0;
         integ_ff   <= '0;
      end else if (load) begin
         started_ff <= started_in;
         last_ff    <= last_in;
         integ_ff   <= integ_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         terms_ff <= terms_in;
      end
   end

   assign terms = terms_ff;

endmodule
`default_nettype wire

/* rtl/core/spp_drive_stage.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Servo position PID drive stage
// Weights the three terms by their gains, drops the gain fraction and
// saturates the sum into the registered drive value, or gives zero inside the deadband.
// ----------------------------------------------------------------------------
module spp_drive_stage #(
   parameter int OUTPUT_LIMIT       = spp_pkg::OUTPUT_LIMIT_DEFAULT,
   parameter int GAIN_FRACTION_BITS = spp_pkg::GAIN_FRACTION_BITS_DEFAULT
) (
   input  logic                                      clock,
   input  logic                                      load,
   input  spp_pkg::cfg_type                          cfg,
   input  spp_pkg::terms_type                        terms,
   output logic signed [$clog2(OUTPUT_LIMIT+1):0]    drive
);
   import spp_pkg::*;

   localparam int DRIVE_W = $clog2(OUTPUT_LIMIT + 1) + 1;
   localparam int MUL_W   = INTEG_W + GAIN_W + 1;
   localparam int ACC_W   = MUL_W + 2;
   localparam logic signed [ACC_W-1:0] LIM_POS = ACC_W'(OUTPUT_LIMIT);
   localparam logic signed [ACC_W-1:0] LIM_NEG = -LIM_POS;

   logic signed [MUL_W-1:0]   prod_p, prod_i, prod_d;
   logic signed [ACC_W-1:0]   acc, acc_shift, acc_sat;
   logic signed [DRIVE_W-1:0] drive_ff, drive_in;

   always_comb begin
      prod_p = $signed(terms.err)   * $signed({1'b0, cfg.prop_gain});
      prod_i = $signed(terms.integ) * $signed({1'b0, cfg.integ_gain});
      prod_d = $signed(terms.deriv) * $signed({1'b0, cfg.deriv_gain});

      acc       = ACC_W'(prod_p) + ACC_W'(prod_i) + ACC_W'(prod_d);
      acc_shift = acc >>> GAIN_FRACTION_BITS;

      if (acc_shift > LIM_POS) begin
         acc_sat = LIM_POS;
      end else if (acc_shift < LIM_NEG) begin
         acc_sat = LIM_NEG;
      end else begin
         acc_sat = acc_shift;
      end

      drive_in = terms.outside ? acc_sat[DRIVE_W-1:0] : $signed(DRIVE_W'(0));
   end

   always_ff @(posedge clock) begin
      if (load) begin
         drive_ff <= drive_in;
      end
   end

   assign drive = drive_ff;

endmodule
`default_nettype wire

/* rtl/core/servo_position_pid.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Servo position PID controller
// Position servo loop with target mirroring, limit clamping, wind-up limited
// integral, deadband and saturated signed drive output.
// ----------------------------------------------------------------------------
// The block takes one position beat per clock while req_stall is low and
// returns one drive beat for each, in order, through an input register, a
// term register holding error, integral and derivative, and the drive register.
// The integral and previous-position state close their loop inside the term
// stage, so consecutive beats see each other's updates at full rate. Stalls
// on the result side reach back combinationally through full stages, and
// the input is stalled only when every stage is full. Configuration writes
// are always ready and must be issued while no beat is in flight.
module servo_position_pid #(
   parameter int POSITION_MAX       = spp_pkg::POSITION_MAX_DEFAULT,
   parameter int OUTPUT_LIMIT       = spp_pkg::OUTPUT_LIMIT_DEFAULT,
   parameter int GAIN_FRACTION_BITS = spp_pkg::GAIN_FRACTION_BITS_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,

   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [$clog2(POSITION_MAX+1)-1:0]      req_measured_position,
   input  logic [$clog2(POSITION_MAX+1)-1:0]      req_target_position,
   input  logic                                   req_tick,

   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [$clog2(OUTPUT_LIMIT+1):0] rsp_drive,

   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [spp_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  logic [spp_pkg::CSR_DATA_W-1:0]         csr_wdata
);
   import spp_pkg::*;

   localparam int POS_W = $clog2(POSITION_MAX + 1);

   cfg_type          cfg_ff, cfg_in, cfg_reset;
   logic             s0_valid_ff, s0_valid_in;
   logic             s1_valid_ff, s1_valid_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [POS_W-1:0] pos_ff, tgt_ff;
   logic             tick_ff;
   logic             adv1, adv2, req_accept, s1_load, out_load;
   terms_type        terms;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_reset              = '0;
      cfg_reset.upper_limit  = LIMIT_W'(POSITION_MAX);
      cfg_reset.windup_limit = WINDUP_RESET;
   end

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_reg_type'(csr_index))
            CSR_DEADBAND:      cfg_in.deadband      = csr_wdata[DEADBAND_W-1:0];
            CSR_PROP_GAIN:     cfg_in.prop_gain     = csr_wdata[GAIN_W-1:0];
            CSR_INTEG_GAIN:    cfg_in.integ_gain    = csr_wdata[GAIN_W-1:0];
            CSR_DERIV_GAIN:    cfg_in.deriv_gain    = csr_wdata[GAIN_W-1:0];
            CSR_LOWER_LIMIT:   cfg_in.lower_limit   = LIMIT_W'(csr_wdata[POS_W-1:0]);
            CSR_UPPER_LIMIT:   cfg_in.upper_limit   = LIMIT_W'(csr_wdata[POS_W-1:0]);
            CSR_REVERSE_SENSE: cfg_in.reverse_sense = csr_wdata[0];
            CSR_WINDUP_LIMIT:  cfg_in.windup_limit  = csr_wdata[WINDUP_W-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= cfg_reset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      adv2       = !rsp_valid_ff || !rsp_stall;
      adv1       = !s1_valid_ff || adv2;
      req_stall  = s0_valid_ff && !adv1;
      req_accept = req_valid && !req_stall;
      s1_load    = s0_valid_ff && adv1;
      out_load   = s1_valid_ff && adv2;

      s0_valid_in  = (!s0_valid_ff || adv1) ? req_valid : s0_valid_ff;
      s1_valid_in  = adv1 ? s0_valid_ff : s1_valid_ff;
      rsp_valid_in = adv2 ? s1_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff  <= s0_valid_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         pos_ff  <= req_measured_position;
         tgt_ff  <= req_target_position;
         tick_ff <= req_tick;
      end
   end

   spp_error_stage #(
      .POSITION_MAX (POSITION_MAX)
   ) u_error (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .load              (s1_load),
      .measured_position (pos_ff),
      .target_position   (tgt_ff),
      .tick              (tick_ff),
      .terms             (terms)
   );

   spp_drive_stage #(
      .OUTPUT_LIMIT       (OUTPUT_LIMIT),
      .GAIN_FRACTION_BITS (GAIN_FRACTION_BITS)
   ) u_drive (
      .clock (clock),
      .load  (out_load),
      .cfg   (cfg_ff),
      .terms (terms),
      .drive (rsp_drive)
   );

   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

/* tb/servo_position_pid_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Servo position PID testbench
// Drives position beats into the controller through a queue-fed driver and
// checks every drive beat against a cycle-free prediction of the servo loop.
// A short directed part covers start-up, the deadband edges, mirrored limits
// and saturation. Random phases then reprogram every register while idle and
// send tracking sequences around a setpoint, mixed with full-range noise.
// Both sides idle in random bursts except during the fourth and the last two random phases.
// ----------------------------------------------------------------------------
module servo_position_pid_test;
   import spp_pkg::*;

   localparam int POS_MAX     = POSITION_MAX_DEFAULT;
   localparam int DRIVE_MAX   = OUTPUT_LIMIT_DEFAULT;
   localparam int FRAC_BITS   = GAIN_FRACTION_BITS_DEFAULT;
   localparam int POS_W       = $clog2(POSITION_MAX_DEFAULT + 1);
   localparam int DRIVE_W     = $clog2(OUTPUT_LIMIT_DEFAULT + 1) + 1;
   localparam int STALL_LIMIT = 1000;

   typedef struct packed {
      logic [POS_W-1:0] measured;
      logic [POS_W-1:0] target;
      logic             tick;
   } position_req_type;

   logic                      clock;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [POS_W-1:0]          req_measured_position = '0;
   logic [POS_W-1:0]          req_target_position = '0;
   logic                      req_tick = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic signed [DRIVE_W-1:0] rsp_drive;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_W-1:0]    csr_index = '0;
   logic [CSR_DATA_W-1:0]     csr_wdata = '0;

   // Register shadows, at their reset values.
   logic [DEADBAND_W-1:0] band_cfg = '0;
   logic [GAIN_W-1:0]     kp_cfg = '0;
   logic [GAIN_W-1:0]     ki_cfg = '0;
   logic [GAIN_W-1:0]     kd_cfg = '0;
   logic [POS_W-1:0]      lo_cfg = '0;
   logic [POS_W-1:0]      hi_cfg = POS_W'(POS_MAX);
   logic                  mirror_cfg = 1'b0;
   logic [WINDUP_W-1:0]   windup_cfg = WINDUP_RESET;

   // Loop state of the predicted controller.
   logic primed = 1'b0;
   int   prev_pos = 0;
   int   integ_acc = 0;

   position_req_type          pending_beats[$];
   logic signed [DRIVE_W-1:0] expected_drives[$];
   position_req_type          next_beat;
   logic signed [DRIVE_W-1:0] want;
   logic                      idle_on = 1'b0;
   int                        gap_left = 0;
   int                        stall_left = 0;
   int                        fail_count = 0;
   int                        quiet_cycles = 0;

   servo_position_pid u_dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_measured_position (req_measured_position),
      .req_target_position   (req_target_position),
      .req_tick              (req_tick),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_drive             (rsp_drive),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic signed [DRIVE_W-1:0] predict_drive(
      input logic [POS_W-1:0] meas, input logic [POS_W-1:0] goal, input logic tick);
      int     tgt, lo, hi, wl, db, err, deriv, sum;
      longint acc;
      tgt = int'(goal);
      lo  = int'(lo_cfg);
      hi  = int'(hi_cfg);
      wl  = int'(windup_cfg);
      db  = int'(band_cfg);
      if (mirror_cfg) begin
         tgt = POS_MAX - tgt;
         lo  = POS_MAX - lo;
         hi  = POS_MAX - hi;
      end
      if (tgt < lo) tgt = lo;
      if (tgt > hi) tgt = hi;
      if (tgt < 0) tgt = 0;
      if (tgt > POS_MAX) tgt = POS_MAX;
      if (!primed) begin
         primed    = 1'b1;
         prev_pos  = int'(meas);
         integ_acc = 0;
      end
      err = tgt - int'(meas);
      if (tick) begin
         sum = integ_acc + err;
         if (sum < -wl) sum = -wl;
         else if (sum > wl) sum = wl;
         integ_acc = sum;
      end
      deriv    = prev_pos - int'(meas);
      prev_pos = int'(meas);
      acc = 0;
      if (err > db || err < -db) begin
         acc = longint'(err) * longint'(kp_cfg) + longint'(integ_acc) * longint'(ki_cfg)
             + longint'(deriv) * longint'(kd_cfg);
      end else begin
         integ_acc = 0;
      end
      acc = acc >>> FRAC_BITS;
      if (acc > DRIVE_MAX) acc = longint'(DRIVE_MAX);
      else if (acc < -DRIVE_MAX) acc = -longint'(DRIVE_MAX);
      return acc[DRIVE_W-1:0];
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_drives.push_back(
               predict_drive(req_measured_position, req_target_position, req_tick));
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_beats.size() != 0) begin
               next_beat = pending_beats.pop_front();
               req_measured_position <= next_beat.measured;
               req_target_position   <= next_beat.target;
               req_tick              <= next_beat.tick;
               req_valid             <= 1'b1;
               if (idle_on && $urandom_range(0, 9) == 0) gap_left = $urandom_range(1, 9);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_drives.size() == 0) begin
               $error("drive beat with no expectation: actual %0d", rsp_drive);
               fail_count++;
            end else begin
               want = expected_drives.pop_front();
               if (rsp_drive !== want) begin
                  $error("drive mismatch: expected %0d, actual %0d", want, rsp_drive);
                  fail_count++;
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (idle_on && $urandom_range(0, 11) == 0) begin
            stall_left = $urandom_range(0, 8);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic write_reg(input csr_reg_type which, input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= which;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (which)
         CSR_DEADBAND:      band_cfg   = value[DEADBAND_W-1:0];
         CSR_PROP_GAIN:     kp_cfg     = value[GAIN_W-1:0];
         CSR_INTEG_GAIN:    ki_cfg     = value[GAIN_W-1:0];
         CSR_DERIV_GAIN:    kd_cfg     = value[GAIN_W-1:0];
         CSR_LOWER_LIMIT:   lo_cfg     = value[POS_W-1:0];
         CSR_UPPER_LIMIT:   hi_cfg     = value[POS_W-1:0];
         CSR_REVERSE_SENSE: mirror_cfg = value[0];
         CSR_WINDUP_LIMIT:  windup_cfg = value[WINDUP_W-1:0];
         default: ;
      endcase
   endtask

   task automatic program_all(input int db, input int kp, input int ki, input int kd,
                              input int lo, input int hi, input int rev, input int wl);
      write_reg(CSR_DEADBAND, CSR_DATA_W'(db));
      write_reg(CSR_PROP_GAIN, CSR_DATA_W'(kp));
      write_reg(CSR_INTEG_GAIN, CSR_DATA_W'(ki));
      write_reg(CSR_DERIV_GAIN, CSR_DATA_W'(kd));
      write_reg(CSR_LOWER_LIMIT, CSR_DATA_W'(lo));
      write_reg(CSR_UPPER_LIMIT, CSR_DATA_W'(hi));
      write_reg(CSR_REVERSE_SENSE, CSR_DATA_W'(rev));
      write_reg(CSR_WINDUP_LIMIT, CSR_DATA_W'(wl));
      csr_valid <= 1'b0;
   endtask

   task automatic queue_beat(input int meas, input int goal, input int tick);
      position_req_type b;
      b.measured = POS_W'(meas);
      b.target   = POS_W'(goal);
      b.tick     = tick[0];
      pending_beats.push_back(b);
   endtask

   // The sender holds off here until every expected drive beat has returned.
   task automatic drain();
      while (pending_beats.size() != 0 || req_valid || expected_drives.size() != 0)
         @(posedge clock);
   endtask

   function automatic int pick_gain();
      case ($urandom_range(0, 5))
         0:       return 0;
         1:       return 16'hFFFF;
         2, 3:    return $urandom_range(0, 1023);
         default: return $urandom_range(0, 16'hFFFF);
      endcase
   endfunction

   function automatic int pick_limit();
      case ($urandom_range(0, 3))
         0:       return 0;
         1:       return POS_MAX;
         default: return $urandom_range(0, POS_MAX);
      endcase
   endfunction

   initial begin
      int phase, n, setpoint, aim, meas, lo, hi, db, wl;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      idle_on <= 1'b1;

      // Start-up, deadband edges, extremes and positions above full scale.
      program_all(4, 16'h0100, 16'h0040, 16'h0080, 0, POS_MAX, 0, 1000);
      queue_beat(100, 200, 1);
      queue_beat(150, 200, 1);
      queue_beat(196, 200, 1);
      queue_beat(195, 200, 0);
      queue_beat(204, 200, 0);
      queue_beat(205, 200, 1);
      queue_beat(0, POS_MAX, 1);
      queue_beat(POS_MAX, 0, 1);
      queue_beat(8191, 8191, 1);
      queue_beat(0, 0, 0);
      queue_beat(POS_MAX, POS_MAX, 1);
      drain();

      // Mirrored limits out of order, full gains, no integral headroom.
      program_all(255, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1000, 3000, 1, 0);
      queue_beat(1096, 500, 1);
      queue_beat(2000, 7000, 1);
      queue_beat(0, POS_MAX, 1);
      queue_beat(POS_MAX, 0, 0);
      queue_beat(8191, 1234, 1);
      drain();

      // Both limits at full scale mirrored to zero, zero deadband.
      program_all(0, 16'h0010, 16'h0100, 16'hFFFF, POS_MAX, POS_MAX, 1, 32767);
      queue_beat(0, POS_MAX, 1);
      queue_beat(1, 17, 1);
      queue_beat(8191, 0, 1);
      queue_beat(0, 8191, 1);
      queue_beat(POS_MAX, POS_MAX, 0);
      queue_beat(2048, 100, 1);
      drain();

      for (phase = 0; phase < 8; phase++) begin
         idle_on <= (phase != 3 && phase < 6);
         case ($urandom_range(0, 3))
            0:       db = 0;
            1:       db = 255;
            default: db = $urandom_range(0, 40);
         endcase
         case ($urandom_range(0, 3))
            0:       wl = 0;
            1:       wl = 32767;
            2:       wl = $urandom_range(0, 3000);
            default: wl = $urandom_range(0, 32767);
         endcase
         if ($urandom_range(0, 2) == 0) begin
            lo = 0;
            hi = POS_MAX;
         end else begin
            lo = pick_limit();
            hi = pick_limit();
         end
         program_all(db, pick_gain(), pick_gain(), pick_gain(), lo, hi,
                     $urandom_range(0, 1), wl);
         setpoint = $urandom_range(0, POS_MAX);
         for (n = 0; n < 104; n++) begin
            if ($urandom_range(0, 3) == 0) begin
               queue_beat($urandom_range(0, 8191), $urandom_range(0, 8191),
                          $urandom_range(0, 1));
            end else begin
               if ($urandom_range(0, 19) == 0) setpoint = $urandom_range(0, POS_MAX);
               aim  = mirror_cfg ? POS_MAX - setpoint : setpoint;
               meas = aim + int'($urandom_range(0, 600)) - 300;
               if (meas < 0) meas = 0;
               if (meas > 8191) meas = 8191;
               queue_beat(meas, setpoint, $urandom_range(0, 1));
            end
         end
         drain();
      end

      repeat (10) @(posedge clock);
      if (fail_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

/* sim.f */
rtl/core/spp_pkg.sv
rtl/core/spp_error_stage.sv
rtl/core/spp_drive_stage.sv
rtl/core/servo_position_pid.sv
tb/servo_position_pid_test.sv
